[design/drt_pkg.sv]
`default_nettype none

package drt_pkg;

    localparam int unsigned CFG_W     = 24;
    localparam int unsigned ELAPSED_W = 32;
    localparam int unsigned FIRES_W   = 25;
    localparam int unsigned TICK_W    = 16;
    localparam int unsigned APB_AW    = 4;
    localparam int unsigned APB_DW    = 32;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_INTERVAL    = 2'd0;
    localparam logic [1:0] REG_DELAY       = 2'd1;
    localparam logic [1:0] REG_REPEAT      = 2'd2;
    localparam logic [1:0] REG_RUN_FOREVER = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DELAY,
        ST_PERIOD,
        ST_LOOP
    } state_t;

    typedef struct packed {
        logic [CFG_W-1:0] interval_ms;
        logic [CFG_W-1:0] delay_ms;
        logic [CFG_W-1:0] repeat_count;
        logic             run_forever;
    } cfg_t;

    typedef struct packed {
        logic arm;
        logic accum;
        logic fire_delay;
        logic set_period;
        logic fire_loop;
    } cmd_t;

    typedef struct packed {
        logic armed;
        logic stopped;
        logic delay_pending;
        logic delay_reached;
        logic can_fire;
        logic last_delay;
        logic last_loop;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

[design/drt_ctrl.sv]
`default_nettype none

module drt_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire drt_pkg::status_t status,
    output drt_pkg::cmd_t        cmd
);

    drt_pkg::state_t state_reg;
    drt_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= drt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            drt_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && !status.stopped)
                begin
                    if (!status.armed)
                    begin
                        cmd.arm = 1'b1;
                    end
                    else
                    begin
                        cmd.accum  = 1'b1;
                        state_next = status.delay_pending ? drt_pkg::ST_DELAY
                                                          : drt_pkg::ST_PERIOD;
                    end
                end
            end
            drt_pkg::ST_DELAY:
            begin
                if (!status.delay_reached)
                begin
                    state_next = drt_pkg::ST_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.fire_delay = 1'b1;
                    state_next     = status.last_delay ? drt_pkg::ST_IDLE
                                                       : drt_pkg::ST_PERIOD;
                end
            end
            drt_pkg::ST_PERIOD:
            begin
                cmd.set_period = 1'b1;
                state_next     = drt_pkg::ST_LOOP;
            end
            drt_pkg::ST_LOOP:
            begin
                if (!status.can_fire)
                begin
                    state_next = drt_pkg::ST_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.fire_loop = 1'b1;
                    if (status.last_loop)
                    begin
                        state_next = drt_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = drt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[design/drt_dpath.sv]
`default_nettype none

module drt_dpath #(
    parameter int unsigned MAX_FIRES_PER_TICK = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire drt_pkg::cfg_t                     cfg,
    input  wire logic [drt_pkg::TICK_W-1:0]        tick_ms,
    input  wire drt_pkg::cmd_t                     cmd,
    output drt_pkg::status_t                       status,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [drt_pkg::ELAPSED_W-1:0]          fire_ms,
    output logic                                   from_delay,
    output logic                                   finished,
    output logic                                   last_of_tick
);

    localparam int unsigned NW = $clog2(MAX_FIRES_PER_TICK + 1);
    localparam logic [NW-1:0] N_MAX = NW'(MAX_FIRES_PER_TICK);
    localparam logic [NW-1:0] N_ONE = NW'(1);
    localparam int unsigned EW = drt_pkg::ELAPSED_W;
    localparam int unsigned FW = drt_pkg::FIRES_W;

    logic          armed_reg;
    logic          stopped_reg;
    logic          delay_pending_reg;
    logic [EW-1:0] elapsed_reg;
    logic [FW-1:0] fires_reg;
    logic [EW-1:0] period_reg;
    logic [NW-1:0] n_reg;

    logic          out_valid_reg;
    logic [EW-1:0] fire_ms_reg;
    logic          from_delay_reg;
    logic          finished_reg;
    logic          last_reg;

    logic [EW:0]   sum;
    logic [EW-1:0] elapsed_sat;
    logic [EW-1:0] delay_ext;
    logic [EW-1:0] interval_ext;
    logic [EW-1:0] after_delay;
    logic [EW-1:0] after_period;
    logic [FW-1:0] fires_inc;
    logic          fin;
    logic [NW-1:0] n_inc;
    logic          out_free;

    assign sum          = {1'b0, elapsed_reg} + {{(EW + 1 - drt_pkg::TICK_W){1'b0}}, tick_ms};
    assign elapsed_sat  = sum[EW] ? {EW{1'b1}} : sum[EW-1:0];
    assign delay_ext    = {{(EW - drt_pkg::CFG_W){1'b0}}, cfg.delay_ms};
    assign interval_ext = {{(EW - drt_pkg::CFG_W){1'b0}}, cfg.interval_ms};
    assign after_delay  = elapsed_reg - delay_ext;
    assign after_period = elapsed_reg - period_reg;

    // Saturating fire count and repeat limit
    assign fires_inc = (&fires_reg) ? fires_reg : fires_reg + FW'(1);
    assign fin = !cfg.run_forever &&
                 (fires_inc > {{(FW - drt_pkg::CFG_W){1'b0}}, cfg.repeat_count});
    assign n_inc = n_reg + N_ONE;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        status               = '0;
        status.armed         = armed_reg;
        status.stopped       = stopped_reg;
        status.delay_pending = delay_pending_reg;
        status.delay_reached = elapsed_reg >= delay_ext;
        status.can_fire      = elapsed_reg >= period_reg;
        // A zero interval lets the loop fire once after the delay fire
        status.last_delay    = fin || (N_ONE >= N_MAX) ||
                               ((cfg.interval_ms != '0) && (after_delay < interval_ext));
        status.last_loop     = fin || (after_period == '0) || (n_inc >= N_MAX) ||
                               (after_period < period_reg);
        status.out_free      = out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg         <= 1'b0;
            stopped_reg       <= 1'b0;
            delay_pending_reg <= 1'b0;
            elapsed_reg       <= '0;
            fires_reg         <= '0;
            n_reg             <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.arm)
            begin
                armed_reg         <= 1'b1;
                elapsed_reg       <= '0;
                fires_reg         <= '0;
                delay_pending_reg <= (cfg.delay_ms != '0);
            end
            if (cmd.accum)
            begin
                elapsed_reg <= elapsed_sat;
                n_reg       <= '0;
            end
            if (cmd.fire_delay)
            begin
                elapsed_reg       <= after_delay;
                delay_pending_reg <= 1'b0;
                fires_reg         <= fires_inc;
                n_reg             <= N_ONE;
                if (fin)
                begin
                    stopped_reg <= 1'b1;
                end
            end
            if (cmd.fire_loop)
            begin
                elapsed_reg <= after_period;
                fires_reg   <= fires_inc;
                n_reg       <= n_inc;
                if (fin)
                begin
                    stopped_reg <= 1'b1;
                end
            end
            if (cmd.fire_delay || cmd.fire_loop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.set_period)
        begin
            period_reg <= (cfg.interval_ms != '0) ? interval_ext : elapsed_reg;
        end
        if (cmd.fire_delay)
        begin
            fire_ms_reg    <= delay_ext;
            from_delay_reg <= 1'b1;
            finished_reg   <= fin;
            last_reg       <= status.last_delay;
        end
        else if (cmd.fire_loop)
        begin
            fire_ms_reg    <= period_reg;
            from_delay_reg <= 1'b0;
            finished_reg   <= fin;
            last_reg       <= status.last_loop;
        end
    end

    assign out_valid    = out_valid_reg;
    assign fire_ms      = fire_ms_reg;
    assign from_delay   = from_delay_reg;
    assign finished     = finished_reg;
    assign last_of_tick = last_reg;

endmodule

`default_nettype wire

[design/delayed_repeating_timer.sv]
`default_nettype none

// Channel  Direction  Handshake             Payload
// -------  ---------  --------------------  --------------------------------------------
// in       input      in_valid / in_ready   tick_ms[15:0]
// out      output     out_valid / out_ready fire_ms[31:0], from_delay, finished, last_of_tick
// apb      input      psel/penable/pready   paddr[3:0], pwdata[31:0], prdata[31:0]
//
// A tick item is taken in the idle state; a pending delay is checked and fired in the delay
// state, the period is loaded in the period state and each loop fire comes from the loop state.
// The fire loop runs over the subtract/compare in the datapath.
// The next tick is taken while the last fire still sits in the output register.
// A stalled output holds the fire loop; the loop resumes the cycle the item is taken.
// Reset clears the timer state and loads the register reset values.

module delayed_repeating_timer #(
    parameter int unsigned MAX_FIRES_PER_TICK = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [drt_pkg::TICK_W-1:0]     tick_ms,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [drt_pkg::ELAPSED_W-1:0]       fire_ms,
    output logic                                from_delay,
    output logic                                finished,
    output logic                                last_of_tick,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [drt_pkg::APB_AW-1:0]     paddr,
    input  wire logic [drt_pkg::APB_DW-1:0]     pwdata,
    output logic [drt_pkg::APB_DW-1:0]          prdata,
    output logic                                pready
);

    drt_pkg::cfg_t    cfg_reg;
    drt_pkg::cmd_t    cmd;
    drt_pkg::status_t status;
    logic [1:0]       reg_idx;
    logic             wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.interval_ms  <= '0;
            cfg_reg.delay_ms     <= '0;
            cfg_reg.repeat_count <= '0;
            cfg_reg.run_forever  <= 1'b1;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                drt_pkg::REG_INTERVAL:    cfg_reg.interval_ms  <= pwdata[drt_pkg::CFG_W-1:0];
                drt_pkg::REG_DELAY:       cfg_reg.delay_ms     <= pwdata[drt_pkg::CFG_W-1:0];
                drt_pkg::REG_REPEAT:      cfg_reg.repeat_count <= pwdata[drt_pkg::CFG_W-1:0];
                drt_pkg::REG_RUN_FOREVER: cfg_reg.run_forever  <= pwdata[0];
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            drt_pkg::REG_INTERVAL:
                prdata = {{(drt_pkg::APB_DW - drt_pkg::CFG_W){1'b0}}, cfg_reg.interval_ms};
            drt_pkg::REG_DELAY:
                prdata = {{(drt_pkg::APB_DW - drt_pkg::CFG_W){1'b0}}, cfg_reg.delay_ms};
            drt_pkg::REG_REPEAT:
                prdata = {{(drt_pkg::APB_DW - drt_pkg::CFG_W){1'b0}}, cfg_reg.repeat_count};
            drt_pkg::REG_RUN_FOREVER:
                prdata = {{(drt_pkg::APB_DW - 1){1'b0}}, cfg_reg.run_forever};
            default:
                prdata = '0;
        endcase
    end

    drt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    drt_dpath #(
        .MAX_FIRES_PER_TICK (MAX_FIRES_PER_TICK)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .tick_ms      (tick_ms),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .fire_ms      (fire_ms),
        .from_delay   (from_delay),
        .finished     (finished),
        .last_of_tick (last_of_tick)
    );

    // A fire only loads the output register when it is free
    a_fire_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.fire_delay || cmd.fire_loop) |-> status.out_free)
        else $error("fire issued while output register is occupied");

    // A stopped timer never fires again
    a_stopped_silent: assert property (@(posedge clk) disable iff (!rst_n)
        status.stopped |-> !(cmd.fire_delay || cmd.fire_loop))
        else $error("fire issued after the timer stopped");

    // A fire that ends the tick returns the controller to idle
    a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.fire_loop && status.last_loop) |=> in_ready)
        else $error("controller kept firing after the last fire of a tick");

endmodule

`default_nettype wire

[verif/drt_checker.sv]
`default_nettype none

module drt_checker #(
    parameter int unsigned MAX_FIRES = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic                          in_ready,
    input  wire logic [drt_pkg::TICK_W-1:0]    tick_ms,
    input  wire logic                          out_valid,
    input  wire logic                          out_ready,
    input  wire logic [drt_pkg::ELAPSED_W-1:0] fire_ms,
    input  wire logic                          from_delay,
    input  wire logic                          finished,
    input  wire logic                          last_of_tick,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic                          pready,
    input  wire logic [drt_pkg::APB_AW-1:0]    paddr,
    input  wire logic [drt_pkg::APB_DW-1:0]    pwdata,
    output int                                 fail_count,
    output int                                 pending,
    output logic [drt_pkg::FIRES_W-1:0]        fire_total
);

    typedef struct packed {
        logic [drt_pkg::ELAPSED_W-1:0] ms;
        logic                          dly;
        logic                          fin;
        logic                          last;
    } fire_t;

    fire_t fire_q[$];

    logic [drt_pkg::CFG_W-1:0]     interval_cfg;
    logic [drt_pkg::CFG_W-1:0]     delay_cfg;
    logic [drt_pkg::CFG_W-1:0]     repeat_cfg;
    logic                          forever_cfg;

    logic                          armed;
    logic                          halted;
    logic                          delay_wait;
    logic [drt_pkg::ELAPSED_W-1:0] elapsed;

    // count one fire; true when the repeat limit stops the timer
    function automatic logic note_fire();
        if (fire_total != '1)
            fire_total = fire_total + {{(drt_pkg::FIRES_W - 1){1'b0}}, 1'b1};
        if (!forever_cfg && fire_total > {1'b0, repeat_cfg})
        begin
            halted = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic predict_tick(input logic [drt_pkg::TICK_W-1:0] tick);
        logic [drt_pkg::ELAPSED_W:0]   sum;
        logic [drt_pkg::ELAPSED_W-1:0] period;
        logic                          fin;
        int                            n;
        n = 0;
        if (halted)
            return;
        if (!armed)
        begin
            armed      = 1'b1;
            elapsed    = '0;
            fire_total = '0;
            delay_wait = (delay_cfg != '0);
            return;
        end
        sum     = {1'b0, elapsed} +
                  {{(drt_pkg::ELAPSED_W + 1 - drt_pkg::TICK_W){1'b0}}, tick};
        elapsed = sum[drt_pkg::ELAPSED_W] ? '1 : sum[drt_pkg::ELAPSED_W-1:0];
        if (delay_wait)
        begin
            if (elapsed < {8'd0, delay_cfg})
                return;
            elapsed    = elapsed - {8'd0, delay_cfg};
            delay_wait = 1'b0;
            fin        = note_fire();
            fire_q.push_back('{ms: {8'd0, delay_cfg}, dly: 1'b1, fin: fin, last: fin});
            n = 1;
            if (fin)
                return;
        end
        // a zero interval takes whatever is left, once per tick
        period = (interval_cfg != '0) ? {8'd0, interval_cfg} : elapsed;
        while (n < MAX_FIRES && elapsed >= period)
        begin
            elapsed = elapsed - period;
            fin     = note_fire();
            fire_q.push_back('{ms: period, dly: 1'b0, fin: fin, last: 1'b0});
            n++;
            if (fin || elapsed == '0)
                break;
        end
        if (n > 0)
            fire_q[fire_q.size()-1].last = 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        fire_t got;
        fire_t want;
        if (!rst_n)
        begin
            fire_q.delete();
            interval_cfg = '0;
            delay_cfg    = '0;
            repeat_cfg   = '0;
            forever_cfg  = 1'b1;
            armed        = 1'b0;
            halted       = 1'b0;
            delay_wait   = 1'b0;
            elapsed      = '0;
            fire_total   = '0;
            fail_count   = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    drt_pkg::REG_INTERVAL:    interval_cfg = pwdata[drt_pkg::CFG_W-1:0];
                    drt_pkg::REG_DELAY:       delay_cfg    = pwdata[drt_pkg::CFG_W-1:0];
                    drt_pkg::REG_REPEAT:      repeat_cfg   = pwdata[drt_pkg::CFG_W-1:0];
                    drt_pkg::REG_RUN_FOREVER: forever_cfg  = pwdata[0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                predict_tick(tick_ms);
            if (out_valid && out_ready)
            begin
                got = '{ms: fire_ms, dly: from_delay, fin: finished, last: last_of_tick};
                if (fire_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected fire: ms=%0d from_delay=%0b finished=%0b last=%0b",
                             $time, got.ms, got.dly, got.fin, got.last);
                end
                else
                begin
                    want = fire_q[0];
                    fire_q.delete(0);
                    if (got.ms !== want.ms || got.dly !== want.dly ||
                        got.fin !== want.fin || got.last !== want.last)
                    begin
                        fail_count++;
                        $display("%0t: fire mismatch: expected ms=%0d from_delay=%0b ",
                                 $time, want.ms, want.dly,
                                 "finished=%0b last=%0b, ", want.fin, want.last,
                                 "got ms=%0d from_delay=%0b ", got.ms, got.dly,
                                 "finished=%0b last=%0b", got.fin, got.last);
                    end
                end
            end
        end
        pending = fire_q.size();
    end

endmodule

`default_nettype wire

[verif/delayed_repeating_timer_tb.sv]
`default_nettype none

module delayed_repeating_timer_tb;

    localparam int unsigned TICK_CAP      = 16;
    localparam int unsigned SETTLE_CYCLES = 40;

    localparam int unsigned CFG_W     = drt_pkg::CFG_W;
    localparam int unsigned TICK_W    = drt_pkg::TICK_W;
    localparam int unsigned ELAPSED_W = drt_pkg::ELAPSED_W;
    localparam int unsigned FIRES_W   = drt_pkg::FIRES_W;
    localparam int unsigned APB_AW    = drt_pkg::APB_AW;
    localparam int unsigned APB_DW    = drt_pkg::APB_DW;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [TICK_W-1:0]    tick_ms;
    logic                 out_valid;
    logic                 out_ready;
    logic [ELAPSED_W-1:0] fire_ms;
    logic                 from_delay;
    logic                 finished;
    logic                 last_of_tick;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [APB_AW-1:0]    paddr;
    logic [APB_DW-1:0]    pwdata;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    int                   fail_count;
    int                   pending;
    logic [FIRES_W-1:0]   fire_total;
    logic                 gaps_on;
    int                   stall_left;
    int                   ready_gap;

    delayed_repeating_timer #(
        .MAX_FIRES_PER_TICK (TICK_CAP)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .tick_ms      (tick_ms),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .fire_ms      (fire_ms),
        .from_delay   (from_delay),
        .finished     (finished),
        .last_of_tick (last_of_tick),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    drt_checker #(
        .MAX_FIRES (TICK_CAP)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .tick_ms      (tick_ms),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .fire_ms      (fire_ms),
        .from_delay   (from_delay),
        .finished     (finished),
        .last_of_tick (last_of_tick),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .fail_count   (fail_count),
        .pending      (pending),
        .fire_total   (fire_total)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // mostly no gap, some short ones, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12)
            return 0;
        if (r < 18)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [CFG_W-1:0] pick_interval();
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return CFG_W'($urandom_range(1, 16));
            2:       return CFG_W'($urandom_range(17, 2000));
            3:       return CFG_W'($urandom_range(2000, 70000));
            4:       return '1;
            5:       return CFG_W'($urandom);
            default: return CFG_W'($urandom_range(100, 1000));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_wide();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            2:       return CFG_W'($urandom);
            default: return CFG_W'($urandom_range(0, 5000));
        endcase
    endfunction

    function automatic logic [TICK_W-1:0] pick_tick();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return TICK_W'($urandom);
            2:       return TICK_W'($urandom_range(0, 100));
            3:       return TICK_W'($urandom_range(100, 3000));
            4:       return '1;
            default: return TICK_W'($urandom_range(0, 20000));
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            ready_gap = gaps_on ? pick_gap() : 0;
            out_ready  <= (ready_gap == 0);
            stall_left <= (ready_gap > 0) ? ready_gap - 1 : 0;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= APB_DW'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // valid stays up after the item is taken unless a gap follows
    task automatic send_tick(input logic [TICK_W-1:0] value);
        int gap;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        tick_ms  <= value;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
    endtask

    // drop valid, wait for every fire, then let a tick with no fire finish
    task automatic drain_fires();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int               phase;
        int               extra;
        logic [CFG_W-1:0] step;
        clk        = 1'b0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        tick_ms    = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        gaps_on    = 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // delay written before the arming tick applies
        write_reg(drt_pkg::REG_DELAY, CFG_W'(1000));
        write_reg(drt_pkg::REG_INTERVAL, CFG_W'(100));
        write_reg(drt_pkg::REG_REPEAT, '0);
        write_reg(drt_pkg::REG_RUN_FOREVER, CFG_W'(1));
        send_tick('1);
        send_tick('0);
        send_tick(TICK_W'(500));
        send_tick(TICK_W'(600));
        send_tick('1);
        send_tick('0);
        send_tick(TICK_W'(16'h5555));
        send_tick(TICK_W'(16'hAAAA));

        // zero interval, live delay write must not restart the delay
        drain_fires();
        write_reg(drt_pkg::REG_INTERVAL, '0);
        write_reg(drt_pkg::REG_DELAY, '1);
        write_reg(drt_pkg::REG_REPEAT, '1);
        send_tick('0);
        send_tick('0);
        send_tick('1);
        send_tick(TICK_W'(1));

        drain_fires();
        write_reg(drt_pkg::REG_INTERVAL, '1);
        send_tick('1);
        send_tick('1);
        send_tick('1);

        // big backlog against the fire cap
        drain_fires();
        write_reg(drt_pkg::REG_INTERVAL, CFG_W'(1));
        send_tick('0);
        send_tick('0);

        for (phase = 0; phase < 8; phase++)
        begin
            drain_fires();
            gaps_on <= (phase % 3) != 2;
            write_reg(drt_pkg::REG_INTERVAL, pick_interval());
            write_reg(drt_pkg::REG_DELAY, pick_wide());
            write_reg(drt_pkg::REG_REPEAT, pick_wide());
            write_reg(drt_pkg::REG_RUN_FOREVER, CFG_W'(1));
            repeat (45)
                send_tick(pick_tick());
        end

        // run to the repeat limit, then keep ticking a stopped timer
        drain_fires();
        gaps_on <= 1'b1;
        step  = CFG_W'($urandom_range(1, 30));
        extra = $urandom_range(2, 20);
        write_reg(drt_pkg::REG_INTERVAL, step);
        write_reg(drt_pkg::REG_REPEAT, CFG_W'(fire_total) + CFG_W'(extra));
        write_reg(drt_pkg::REG_RUN_FOREVER, '0);
        repeat (extra + 7)
            send_tick(TICK_W'($urandom_range(step, 20 * step)));
        drain_fires();

        if (fail_count == 0)
            $display("delayed_repeating_timer_tb OK");
        else
            $display("delayed_repeating_timer_tb NOT OK");
        $finish;
    end

    initial
    begin
        #30000000;
        $display("delayed_repeating_timer_tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
